/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms used by the checker
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define ASSERT_NOW(label, ante, cons, clk, rst_n) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// consequent checked in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, clk, rst_n) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* design/scrt_pkg.sv */
// ----------------------------------------------------------------------------
// scrt_pkg
// types and constants shared by the slave clock rate tracker
// ----------------------------------------------------------------------------
package scrt_pkg;

  localparam int unsigned TIME_BITS_DEF      = 32;
  localparam int unsigned RATE_FRAC_BITS_DEF = 28;

  localparam int unsigned TIME_W = 32;
  localparam int unsigned RATE_W = 32;
  localparam int unsigned GAIN_W = 16;

  localparam logic [GAIN_W-1:0] LOOP_GAIN_RST = 16'd655;

  // configuration register indexes
  localparam logic CFG_SLAVED    = 1'b0;
  localparam logic CFG_LOOP_GAIN = 1'b1;

  typedef enum logic [1:0] {
    OP_CAL_FIRST  = 2'd0,
    OP_CAL_SECOND = 2'd1,
    OP_UPDATE     = 2'd2,
    OP_MAP        = 2'd3
  } op_e;

  typedef struct packed {
    op_e               opcode;
    logic [TIME_W-1:0] master_ts;
    logic [TIME_W-1:0] slave_time;
  } in_item_t;

  typedef struct packed {
    logic [TIME_W-1:0] mapped_time;
    logic [RATE_W-1:0] rate_now;
    logic              zero_delta;
  } out_item_t;

  typedef enum logic {
    UOP_MUL = 1'b0,
    UOP_DIV = 1'b1
  } unit_op_e;

  typedef struct packed {
    logic     start;
    unit_op_e op;
  } unit_req_t;

endpackage

/* design/slave_clock_rate_tracker_core.sv */
// ----------------------------------------------------------------------------
// slave_clock_rate_tracker_core
// tracks slave clock rate against a master clock and maps master timestamps
// ----------------------------------------------------------------------------
//
//  channel   signals                          direction  width
//  input     in_valid_i/in_ready_o/in_data_i   in         66
//  output    out_valid_o/out_ready_i/out_data_o out       65
//  config    cfg_we_i/cfg_idx_i/cfg_data_i     in         1+1+16
//
//  one transaction in flight; in_ready_o is high only when the sequencer idles
//  transaction length is set by the bit-serial multiply/divide unit: a map
//  runs one multiply, second calibration one divide, rate update a multiply
//  then a divide; a zero master delta and everything else skip the unit
//  the result sits in an output register, so a new transaction is taken
//  while it waits; the sequencer stalls only if a second result is ready
//  reset clears rate, error, bases and calibration samples; no clearing pass
//
module slave_clock_rate_tracker_core #(
  parameter int unsigned TIME_BITS      = scrt_pkg::TIME_BITS_DEF,
  parameter int unsigned RATE_FRAC_BITS = scrt_pkg::RATE_FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  scrt_pkg::in_item_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output scrt_pkg::out_item_t           out_data_o,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [scrt_pkg::GAIN_W-1:0]   cfg_data_i
);

  localparam int unsigned TB = TIME_BITS;
  localparam int unsigned RW = scrt_pkg::RATE_W;
  localparam int unsigned GW = scrt_pkg::GAIN_W;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DELTA,
    S_START,
    S_MAP_WAIT,
    S_CAL_WAIT,
    S_EST_WAIT,
    S_MEAS_WAIT,
    S_GAIN,
    S_UPDATE,
    S_OUT
  } state_e;

  state_e               state_q;
  logic                 slaved_q;
  logic [GW-1:0]        gain_q;
  logic [RW-1:0]        rate_q;
  logic [RW-1:0]        err_q;
  logic [TB-1:0]        mb_q;
  logic [TB-1:0]        sb_q;
  logic [TB-1:0]        fm_q;
  logic [TB-1:0]        fs_q;

  scrt_pkg::op_e        op_q;
  logic [TB-1:0]        mt_q;
  logic [TB-1:0]        st_q;
  logic [TB-1:0]        dm_q;
  logic [TB-1:0]        ds_q;
  logic                 neg_q;
  logic [TB-1:0]        est_q;
  logic [RW-1:0]        adj_q;
  logic [TB-1:0]        mapped_q;
  logic                 zflag_q;
  logic                 out_valid_q;
  scrt_pkg::out_item_t  out_data_q;

  logic [TB-1:0]        base_m;
  logic [TB-1:0]        base_s;
  logic [TB-1:0]        diff_m;
  logic [TB-1:0]        diff_s;
  scrt_pkg::unit_req_t  ureq;
  logic [TB-1:0]        u_opnd;
  logic                 u_done;
  logic [TB-1:0]        u_prod;
  logic [RW-1:0]        u_quo;
  logic signed [RW:0]   err_ext;
  logic [RW-1:0]        err_sat;
  logic signed [48:0]   gprod;
  logic signed [RW+1:0] nr;
  logic                 out_free;

  assign in_ready_o = (state_q == S_IDLE);
  assign out_free   = !out_valid_q || out_ready_i;

  // deltas; for a map the second difference is the negated delta
  always_comb begin
    base_m = (op_q == scrt_pkg::OP_CAL_SECOND) ? fm_q : mb_q;
    base_s = (op_q == scrt_pkg::OP_CAL_SECOND) ? fs_q : sb_q;
    diff_m = mt_q - base_m;
    diff_s = (op_q == scrt_pkg::OP_MAP) ? (mb_q - mt_q) : (st_q - base_s);
  end

  always_comb begin
    ureq.start = 1'b0;
    ureq.op    = scrt_pkg::UOP_MUL;
    if (state_q == S_START) begin
      unique case (op_q)
        scrt_pkg::OP_MAP: begin
          ureq.start = 1'b1;
        end
        scrt_pkg::OP_CAL_SECOND: begin
          ureq.start = (dm_q != '0);
          ureq.op    = scrt_pkg::UOP_DIV;
        end
        scrt_pkg::OP_UPDATE: begin
          ureq.start = (dm_q != '0);
        end
        default: begin
          ureq.start = 1'b0;
        end
      endcase
    end else if (state_q == S_EST_WAIT) begin
      ureq.start = u_done;
      ureq.op    = scrt_pkg::UOP_DIV;
    end
    u_opnd = (op_q == scrt_pkg::OP_MAP && dm_q[TB-1]) ? ds_q : dm_q;
  end

  scrt_muldiv #(
    .TIME_BITS      (TIME_BITS),
    .RATE_FRAC_BITS (RATE_FRAC_BITS)
  ) u_muldiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (ureq),
    .mcand_i (rate_q),
    .num_i   (ds_q),
    .opnd_i  (u_opnd),
    .done_o  (u_done),
    .prod_o  (u_prod),
    .quo_o   (u_quo)
  );

  // error = measured - rate, clipped to the signed 32-bit range
  always_comb begin
    err_ext = $signed({1'b0, u_quo}) - $signed({1'b0, rate_q});
    if (err_ext[RW] != err_ext[RW-1]) begin
      err_sat = err_ext[RW] ? {1'b1, {(RW-1){1'b0}}} : {1'b0, {(RW-1){1'b1}}};
    end else begin
      err_sat = err_ext[RW-1:0];
    end
    gprod = $signed({1'b0, gain_q}) * $signed(err_q);
    nr    = $signed({2'b00, rate_q}) + $signed({{2{adj_q[RW-1]}}, adj_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      slaved_q    <= 1'b0;
      gain_q      <= scrt_pkg::LOOP_GAIN_RST;
      rate_q      <= '0;
      err_q       <= '0;
      mb_q        <= '0;
      sb_q        <= '0;
      fm_q        <= '0;
      fs_q        <= '0;
      op_q        <= scrt_pkg::OP_CAL_FIRST;
      mt_q        <= '0;
      st_q        <= '0;
      dm_q        <= '0;
      ds_q        <= '0;
      neg_q       <= 1'b0;
      est_q       <= '0;
      adj_q       <= '0;
      mapped_q    <= '0;
      zflag_q     <= 1'b0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          scrt_pkg::CFG_SLAVED:    slaved_q <= cfg_data_i[0];
          scrt_pkg::CFG_LOOP_GAIN: gain_q   <= cfg_data_i;
          default:                 slaved_q <= slaved_q;
        endcase
      end

      if (state_q == S_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            op_q    <= in_data_i.opcode;
            mt_q    <= TB'(in_data_i.master_ts);
            st_q    <= TB'(in_data_i.slave_time);
            state_q <= S_DELTA;
          end
        end
        S_DELTA: begin
          dm_q     <= diff_m;
          ds_q     <= diff_s;
          zflag_q  <= 1'b0;
          mapped_q <= (op_q == scrt_pkg::OP_MAP && !slaved_q) ? mt_q : '0;
          if (!slaved_q) begin
            state_q <= S_OUT;
          end else if (op_q == scrt_pkg::OP_CAL_FIRST) begin
            fm_q    <= mt_q;
            fs_q    <= st_q;
            state_q <= S_OUT;
          end else begin
            state_q <= S_START;
          end
        end
        S_START: begin
          neg_q <= dm_q[TB-1];
          unique case (op_q)
            scrt_pkg::OP_MAP: begin
              state_q <= S_MAP_WAIT;
            end
            scrt_pkg::OP_CAL_SECOND: begin
              if (dm_q == '0) begin
                zflag_q <= 1'b1;
                state_q <= S_OUT;
              end else begin
                state_q <= S_CAL_WAIT;
              end
            end
            scrt_pkg::OP_UPDATE: begin
              if (dm_q == '0) begin
                zflag_q <= 1'b1;
                state_q <= S_OUT;
              end else begin
                state_q <= S_EST_WAIT;
              end
            end
            default: begin
              state_q <= S_OUT;
            end
          endcase
        end
        S_MAP_WAIT: begin
          if (u_done) begin
            mapped_q <= neg_q ? (sb_q - u_prod) : (sb_q + u_prod);
            state_q  <= S_OUT;
          end
        end
        S_CAL_WAIT: begin
          if (u_done) begin
            rate_q  <= u_quo;
            mb_q    <= mt_q;
            sb_q    <= st_q;
            state_q <= S_OUT;
          end
        end
        S_EST_WAIT: begin
          // divide is launched in the same cycle the estimate lands
          if (u_done) begin
            est_q   <= u_prod;
            state_q <= S_MEAS_WAIT;
          end
        end
        S_MEAS_WAIT: begin
          if (u_done) begin
            err_q   <= err_sat;
            state_q <= S_GAIN;
          end
        end
        S_GAIN: begin
          // arithmetic shift gives floor of the scaled correction
          adj_q   <= gprod[47:16];
          state_q <= S_UPDATE;
        end
        S_UPDATE: begin
          if (nr[RW+1]) begin
            rate_q <= '0;
          end else if (nr[RW]) begin
            rate_q <= '1;
          end else begin
            rate_q <= nr[RW-1:0];
          end
          mb_q    <= mt_q;
          sb_q    <= sb_q + est_q;
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_data_q.mapped_time <= scrt_pkg::TIME_W'(mapped_q);
            out_data_q.rate_now    <= rate_q;
            out_data_q.zero_delta  <= zflag_q;
            state_q                <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

/* design/scrt_muldiv.sv */
// ----------------------------------------------------------------------------
// scrt_muldiv
// bit-serial multiply / restoring divide unit sharing one adder
// ----------------------------------------------------------------------------
module scrt_muldiv #(
  parameter int unsigned TIME_BITS      = scrt_pkg::TIME_BITS_DEF,
  parameter int unsigned RATE_FRAC_BITS = scrt_pkg::RATE_FRAC_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  scrt_pkg::unit_req_t          req_i,
  input  logic [scrt_pkg::RATE_W-1:0]  mcand_i,
  input  logic [TIME_BITS-1:0]         num_i,
  input  logic [TIME_BITS-1:0]         opnd_i,
  output logic                         done_o,
  output logic [TIME_BITS-1:0]         prod_o,
  output logic [scrt_pkg::RATE_W-1:0]  quo_o
);

  localparam int unsigned RW = scrt_pkg::RATE_W;
  localparam int unsigned PW = TIME_BITS + RW;
  localparam int unsigned AW = PW + 1;
  localparam int unsigned SW = TIME_BITS + RATE_FRAC_BITS;
  localparam int unsigned CW = $clog2(SW);

  logic                busy_q;
  logic                done_q;
  logic [CW-1:0]       cnt_q;
  scrt_pkg::unit_op_e  op_q;
  logic [PW-1:0]       acc_q;
  logic [SW-1:0]       shreg_q;
  logic [TIME_BITS-1:0] opnd_q;
  logic [RW-1:0]       q_q;
  logic                sat_q;

  logic [PW-1:0]       shifted;
  logic [AW-1:0]       addend;
  logic                cin;
  logic [AW-1:0]       sum;
  logic                ge;
  logic [RW:0]         q_ext;
  logic                sat_d;
  logic [RW-1:0]       q_d;
  logic [PW-1:0]       acc_d;

  // shared adder: add for multiply, subtract divisor for divide
  always_comb begin
    if (op_q == scrt_pkg::UOP_DIV) begin
      shifted = {acc_q[PW-2:0], shreg_q[SW-1]};
      addend  = ~{1'b0, PW'(opnd_q)};
      cin     = 1'b1;
    end else begin
      shifted = {acc_q[PW-2:0], 1'b0};
      addend  = shreg_q[SW-1] ? {1'b0, PW'(opnd_q)} : '0;
      cin     = 1'b0;
    end
    sum   = {1'b0, shifted} + addend + AW'(cin);
    ge    = ~sum[PW];
    q_ext = {q_q, ge};
    sat_d = sat_q | q_ext[RW];
    q_d   = sat_d ? '1 : q_ext[RW-1:0];
    if (op_q == scrt_pkg::UOP_DIV) begin
      acc_d = ge ? sum[PW-1:0] : shifted;
    end else begin
      acc_d = sum[PW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= (req_i.op == scrt_pkg::UOP_DIV) ? CW'(SW - 1) : CW'(RW - 1);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        cnt_q <= cnt_q - CW'(1);
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      op_q   <= req_i.op;
      acc_q  <= '0;
      opnd_q <= opnd_i;
      q_q    <= '0;
      sat_q  <= 1'b0;
      if (req_i.op == scrt_pkg::UOP_DIV) begin
        shreg_q <= SW'(num_i) << RATE_FRAC_BITS;
      end else begin
        shreg_q <= SW'(mcand_i) << (SW - RW);
      end
    end else if (busy_q) begin
      acc_q   <= acc_d;
      shreg_q <= {shreg_q[SW-2:0], 1'b0};
      q_q     <= q_d;
      sat_q   <= sat_d;
    end
  end

  assign done_o = done_q;
  assign prod_o = TIME_BITS'(acc_q >> RATE_FRAC_BITS);
  assign quo_o  = q_q;

endmodule

/* design/scrt_checker.sv */
// ----------------------------------------------------------------------------
// scrt_checker
// port-level checks on the slave clock rate tracker
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module scrt_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input scrt_pkg::out_item_t          out_data_o
);

  logic zero_res;

  assign zero_res = out_valid_o && out_data_o.zero_delta;

  // one transaction at a time: accepting closes the input
  `ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o, clk_i, rst_ni)

  // a zero master delta only comes from calibration or update, never a map
  `ASSERT_NOW(a_zero_delta_no_map, zero_res, out_data_o.mapped_time == '0, clk_i, rst_ni)

  `ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o, clk_i, rst_ni)

  `ASSERT_NEXT(a_out_stable, out_valid_o && !out_ready_i, $stable(out_data_o), clk_i, rst_ni)

endmodule

bind slave_clock_rate_tracker_core scrt_checker u_scrt_checker (.*);

/* sim/slave_clock_rate_tracker_core_tb.sv */
// ----------------------------------------------------------------------------
// slave_clock_rate_tracker_core_tb
// self-checking bench: directed and randomized timestamp streams are sent
// through the tracker and every output is compared with a local rate model
// ----------------------------------------------------------------------------
module slave_clock_rate_tracker_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FRAC        = scrt_pkg::RATE_FRAC_BITS_DEF;
  localparam int unsigned GW          = scrt_pkg::GAIN_W;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;

  // --------------------------------------------------------------------------
  // rate model and result store
  // --------------------------------------------------------------------------
  class rate_tracker_scoreboard;
    logic                slaved_q;
    logic [GW-1:0]       gain_q;
    logic [31:0]         rate_q;
    logic [31:0]         rate_err_q;
    logic [31:0]         m_base_q;
    logic [31:0]         s_base_q;
    logic [31:0]         m_first_q;
    logic [31:0]         s_first_q;
    scrt_pkg::out_item_t predicted_outputs[$];
    int unsigned         failures;

    function void reset_state();
      slaved_q   = 1'b0;
      gain_q     = scrt_pkg::LOOP_GAIN_RST;
      rate_q     = '0;
      rate_err_q = '0;
      m_base_q   = '0;
      s_base_q   = '0;
      m_first_q  = '0;
      s_first_q  = '0;
      failures   = 0;
    endfunction

    function void write_reg(logic idx, logic [GW-1:0] value);
      if (idx == scrt_pkg::CFG_SLAVED) begin
        slaved_q = value[0];
      end else begin
        gain_q = value;
      end
    endfunction

    function int unsigned pending();
      return predicted_outputs.size();
    endfunction

    // floor(ds * 2^FRAC / dm), saturated to 32 bits
    function logic [31:0] rate_quotient(logic [31:0] ds, logic [31:0] dm);
      logic [63:0] q;
      q = ({32'd0, ds} << FRAC) / {32'd0, dm};
      return (q > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
    endfunction

    function logic [63:0] rate_scaled(logic [31:0] rate, logic [31:0] d);
      return ({32'd0, rate} * {32'd0, d}) >> FRAC;
    endfunction

    function void note_input(scrt_pkg::in_item_t it);
      scrt_pkg::out_item_t res;
      logic [31:0]         d;
      logic [31:0]         dm;
      logic [31:0]         ds;
      logic [63:0]         est;
      logic signed [63:0]  err;
      logic signed [63:0]  prod;
      logic signed [63:0]  nr;
      res = '0;
      if (it.opcode == scrt_pkg::OP_MAP) begin
        if (!slaved_q) begin
          res.mapped_time = it.master_ts;
        end else begin
          d = it.master_ts - m_base_q;
          // negative distance from the base interpolates backward
          if (d[31]) begin
            est = rate_scaled(rate_q, 32'd0 - d);
            res.mapped_time = s_base_q - est[31:0];
          end else begin
            est = rate_scaled(rate_q, d);
            res.mapped_time = s_base_q + est[31:0];
          end
        end
      end else if (slaved_q) begin
        case (it.opcode)
          scrt_pkg::OP_CAL_FIRST: begin
            m_first_q = it.master_ts;
            s_first_q = it.slave_time;
          end
          scrt_pkg::OP_CAL_SECOND: begin
            dm = it.master_ts - m_first_q;
            ds = it.slave_time - s_first_q;
            if (dm == '0) begin
              res.zero_delta = 1'b1;
            end else begin
              rate_q   = rate_quotient(ds, dm);
              m_base_q = it.master_ts;
              s_base_q = it.slave_time;
            end
          end
          default: begin
            dm = it.master_ts - m_base_q;
            ds = it.slave_time - s_base_q;
            if (dm == '0) begin
              res.zero_delta = 1'b1;
            end else begin
              est = rate_scaled(rate_q, dm);
              err = $signed({32'd0, rate_quotient(ds, dm)}) - $signed({32'd0, rate_q});
              if (err > 64'sd2147483647) err = 64'sd2147483647;
              if (err < -64'sd2147483648) err = -64'sd2147483648;
              rate_err_q = err[31:0];
              prod = $signed({48'd0, gain_q}) * err;
              // arithmetic shift rounds toward minus infinity on both signs
              nr = $signed({32'd0, rate_q}) + (prod >>> 16);
              if (nr < 64'sd0) nr = 64'sd0;
              if (nr > 64'sd4294967295) nr = 64'sd4294967295;
              rate_q   = nr[31:0];
              m_base_q = it.master_ts;
              s_base_q = s_base_q + est[31:0];
            end
          end
        endcase
      end
      res.rate_now = rate_q;
      predicted_outputs.insert(predicted_outputs.size(), res);
    endfunction

    function void flag_field(string field, logic [31:0] want, logic [31:0] got);
      failures++;
      if (failures <= 10) begin
        $display("%0t: %s mismatch, expected %h, got %h", $realtime, field, want, got);
      end
    endfunction

    function void check_result(scrt_pkg::out_item_t got);
      scrt_pkg::out_item_t want;
      if (predicted_outputs.size() == 0) begin
        failures++;
        if (failures <= 10) begin
          $display("%0t: unexpected transaction, mapped %h rate %h zero %b", $realtime,
                   got.mapped_time, got.rate_now, got.zero_delta);
        end
        return;
      end
      want = predicted_outputs.pop_front();
      if (got.mapped_time !== want.mapped_time) begin
        flag_field("mapped_time", want.mapped_time, got.mapped_time);
      end
      if (got.rate_now !== want.rate_now) begin
        flag_field("rate_now", want.rate_now, got.rate_now);
      end
      if (got.zero_delta !== want.zero_delta) begin
        flag_field("zero_delta", {31'd0, want.zero_delta}, {31'd0, got.zero_delta});
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // signals and block
  // --------------------------------------------------------------------------
  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  scrt_pkg::in_item_t  in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  scrt_pkg::out_item_t out_data;
  logic                cfg_we    = 1'b0;
  logic                cfg_idx   = scrt_pkg::CFG_SLAVED;
  logic [GW-1:0]       cfg_data  = '0;

  rate_tracker_scoreboard sb;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned cycles         = 0;

  // timestamp stream state
  logic [31:0] m_now   = 32'h0100_0000;
  logic [31:0] s_now   = 32'h0200_0000;
  logic [31:0] cal_mt  = '0;
  logic [31:0] base_mt = '0;
  int unsigned cal_stage = 0;

  slave_clock_rate_tracker_core i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // result side: check on handshake, then pick the next ready level
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_result(out_data);
    end
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // --------------------------------------------------------------------------
  // drivers
  // --------------------------------------------------------------------------
  task automatic send_item(input scrt_pkg::in_item_t it);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(it);
  endtask

  task automatic write_config(input logic slaved, input logic [GW-1:0] gain);
    cfg_we   <= 1'b1;
    cfg_idx  <= scrt_pkg::CFG_SLAVED;
    cfg_data <= {{(GW-1){1'b0}}, slaved};
    sb.write_reg(scrt_pkg::CFG_SLAVED, {{(GW-1){1'b0}}, slaved});
    @(posedge clk);
    cfg_idx  <= scrt_pkg::CFG_LOOP_GAIN;
    cfg_data <= gain;
    sb.write_reg(scrt_pkg::CFG_LOOP_GAIN, gain);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic settle(input int unsigned extra);
    while (sb.pending() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  function automatic scrt_pkg::in_item_t mk(scrt_pkg::op_e op, logic [31:0] mt,
                                            logic [31:0] st);
    scrt_pkg::in_item_t it;
    it.opcode     = op;
    it.master_ts  = mt;
    it.slave_time = st;
    return it;
  endfunction

  function automatic void step_clocks();
    logic [31:0] dm;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      dm = $urandom_range(1, 5000);
    end else if (pick < 95) begin
      dm = $urandom_range(1, 1 << 20);
    end else begin
      dm = $urandom;
    end
    m_now = m_now + dm;
    // slave runs within a few percent of the master
    s_now = s_now + dm + $urandom_range(0, dm >> 5) - (dm >> 6);
  endfunction

  // mostly calibrate-then-track sequences, with noise and zero deltas mixed in
  function automatic scrt_pkg::in_item_t next_stream_item();
    scrt_pkg::in_item_t it;
    int unsigned        r;
    r = $urandom_range(0, 99);
    it.opcode     = scrt_pkg::op_e'($urandom_range(0, 3));
    it.master_ts  = $urandom;
    it.slave_time = $urandom;
    if (r < 8) return it;
    if (r < 11) begin
      if (r[0]) begin
        it.opcode    = scrt_pkg::OP_CAL_SECOND;
        it.master_ts = cal_mt;
      end else begin
        it.opcode    = scrt_pkg::OP_UPDATE;
        it.master_ts = base_mt;
      end
      return it;
    end
    if (r < 14) cal_stage = 0;
    if (cal_stage != 2 || r < 50) begin
      step_clocks();
      it.master_ts  = m_now;
      it.slave_time = s_now;
      case (cal_stage)
        0: begin
          it.opcode = scrt_pkg::OP_CAL_FIRST;
          cal_mt    = m_now;
          cal_stage = 1;
        end
        1: begin
          it.opcode = scrt_pkg::OP_CAL_SECOND;
          base_mt   = m_now;
          cal_stage = 2;
        end
        default: begin
          it.opcode = scrt_pkg::OP_UPDATE;
          base_mt   = m_now;
        end
      endcase
    end else begin
      it.opcode = scrt_pkg::OP_MAP;
      if (r < 60) begin
        it.master_ts = $urandom;
      end else begin
        it.master_ts = m_now + $urandom_range(0, 1 << 17) - (1 << 16);
      end
    end
    return it;
  endfunction

  task automatic run_phase(input logic slaved, input logic [GW-1:0] gain,
                           input int unsigned send_pct, input int unsigned recv_pct,
                           input int unsigned count);
    settle(8);
    write_config(slaved, gain);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    cal_stage      = 0;
    repeat (count) send_item(next_stream_item());
    in_valid <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // sequence
  // --------------------------------------------------------------------------
  initial begin
    sb = new;
    sb.reset_state();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    write_config(1'b0, scrt_pkg::LOOP_GAIN_RST);

    // not slaved: maps pass through, everything else is ignored
    send_item(mk(scrt_pkg::OP_MAP, 32'h0000_0000, 32'hFFFF_FFFF));
    send_item(mk(scrt_pkg::OP_MAP, 32'hFFFF_FFFF, 32'h0000_0000));
    send_item(mk(scrt_pkg::OP_CAL_FIRST, 32'h0000_0010, 32'h0000_0020));
    send_item(mk(scrt_pkg::OP_CAL_SECOND, 32'h0000_1010, 32'h0000_2020));
    send_item(mk(scrt_pkg::OP_UPDATE, 32'h0000_2010, 32'h0000_3020));
    in_valid <= 1'b0;
    settle(8);
    write_config(1'b1, scrt_pkg::LOOP_GAIN_RST);

    send_item(mk(scrt_pkg::OP_MAP, 32'h1234_5678, 32'h0));
    send_item(mk(scrt_pkg::OP_CAL_FIRST, 32'd0, 32'd0));
    send_item(mk(scrt_pkg::OP_CAL_SECOND, 32'd0, 32'd5));          // zero master delta
    send_item(mk(scrt_pkg::OP_CAL_SECOND, 32'd1_000_000, 32'd1_000_500));
    send_item(mk(scrt_pkg::OP_MAP, 32'd1_500_000, 32'h0));
    send_item(mk(scrt_pkg::OP_MAP, 32'd500_000, 32'h0));           // behind the base
    send_item(mk(scrt_pkg::OP_MAP, 32'd1_000_000 + 32'h8000_0000, 32'h0));
    send_item(mk(scrt_pkg::OP_UPDATE, 32'd2_000_000, 32'd2_000_300));
    send_item(mk(scrt_pkg::OP_UPDATE, 32'd2_000_000, 32'd7));      // zero master delta
    send_item(mk(scrt_pkg::OP_UPDATE, 32'h0000_1000, 32'hFFFF_FFFF)); // wrapped delta
    send_item(mk(scrt_pkg::OP_CAL_FIRST, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    // rate saturates
    send_item(mk(scrt_pkg::OP_CAL_SECOND, 32'h0000_0000, 32'hFFFF_FFFE));
    send_item(mk(scrt_pkg::OP_MAP, 32'hFFFF_FFFF, 32'h0));
    // error clips low
    send_item(mk(scrt_pkg::OP_UPDATE, 32'h0000_0002, 32'h0000_0000));
    send_item(mk(scrt_pkg::OP_UPDATE, 32'h0001_0002, 32'h0008_0000));
    send_item(mk(scrt_pkg::OP_CAL_FIRST, 32'd100, 32'd0));
    // tiny rate
    send_item(mk(scrt_pkg::OP_CAL_SECOND, 32'd100 + 32'h1000_0000, 32'd1));
    // error clips high
    send_item(mk(scrt_pkg::OP_UPDATE, 32'd101 + 32'h1000_0000, 32'hFFFF_FFF0));
    send_item(mk(scrt_pkg::OP_MAP, 32'h0000_0000, 32'h0));
    in_valid <= 1'b0;

    run_phase(1'b1, scrt_pkg::LOOP_GAIN_RST,  0,  0, 220);
    run_phase(1'b1, 16'hFFFF,                79,  0, 220);
    run_phase(1'b1, 16'h0000,                 0, 79, 220);
    run_phase(1'b1, 16'($urandom),           34, 34, 220);
    run_phase(1'b0, 16'($urandom),            0,  0,  80);
    run_phase(1'b1, 16'h0001,                34, 34, 220);

    settle(200);
    if (sb.failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
